>>> hdl/best_fit_heap_allocator_top_macros.svh
// Assertion macros used by the allocator checker.
`ifndef BEST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH
`define BEST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define BFHA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator port check failed");

// Next-cycle implication, disabled while rst is high.
`define BFHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator port check failed");

`endif

>>> hdl/bfha_pkg.sv
`default_nettype none
package bfha_pkg;

   localparam int HEAP_WORDS_DEFAULT = 65536;
   localparam int BYTE_W = 18;
   localparam int ADDR_W = 16;
   localparam int TRIM_MIN_WORDS = 4;

   typedef enum logic [1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_FREE   = 2'd1,
      CMD_RESIZE = 2'd2
   } cmd_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [BYTE_W-1:0]  size_bytes;
      logic [ADDR_W-1:0]  block_addr;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  result_addr;
      logic               ok;
      logic               moved;
      logic [BYTE_W-1:0]  copy_bytes;
      logic [BYTE_W-1:0]  bytes_free;
   } rsp_type;

   // Datapath operation issued by the controller each cycle.
   typedef enum logic [4:0] {
      OP_NONE,
      OP_INIT,
      OP_LOAD,
      OP_RD_H,
      OP_SKIP,
      OP_LATCH,
      OP_VALID,
      OP_RD_NX,
      OP_MERGE_A,
      OP_MERGE_R,
      OP_FIT,
      OP_ALLOC_START,
      OP_TAKE,
      OP_SPLIT,
      OP_FREE,
      OP_TRIM,
      OP_TRIM2,
      OP_RES_FAIL,
      OP_RES_FREE,
      OP_RES_ADDR,
      OP_RES_BEST
   } op_type;

   typedef struct packed {
      cmd_type cmd;
      logic    bad_addr;
      logic    h_end;
      logic    h_past_tgt;
      logic    h_eq_tgt;
      logic    rd_free;
      logic    nx_end;
      logic    cur_ge_want;
      logic    trim_ok;
      logic    found;
      logic    split;
   } dp_status_type;

endpackage
`default_nettype wire

>>> hdl/bfha_dp.sv
`default_nettype none
module bfha_dp #(
   parameter int HEAP_WORDS = bfha_pkg::HEAP_WORDS_DEFAULT
) (
   input  wire                     clock,
   input  bfha_pkg::op_type        op,
   input  bfha_pkg::req_type       req_data,
   output bfha_pkg::dp_status_type status,
   output bfha_pkg::rsp_type       rsp_data
);

   localparam int AW = $clog2(HEAP_WORDS);
   localparam int PW = ((AW > bfha_pkg::ADDR_W) ? AW : bfha_pkg::ADDR_W) + 1;
   localparam int SW = PW + 1;
   localparam int BW = bfha_pkg::BYTE_W;
   localparam logic [SW-1:0] HW_S = SW'(HEAP_WORDS);
   localparam logic [SW-1:0] ONE = SW'(1);
   localparam logic [SW-1:0] TRIM_S = SW'(bfha_pkg::TRIM_MIN_WORDS);
   localparam logic [BW-1:0] FBC_RESET = BW'((HEAP_WORDS - 1) * 4);
   localparam logic [AW-1:0] TOP_SIZE = AW'(HEAP_WORDS - 1);

   function automatic logic [BW-1:0] to_bytes(input logic [SW-1:0] w);
      to_bytes = {w[BW-3:0], 2'b00};
   endfunction

   // Each entry: free flag on top, payload words below.
   logic [AW:0] mem [HEAP_WORDS];
   logic [AW:0] rd_ff;

   bfha_pkg::cmd_type cmd_ff;
   logic [SW-1:0] want_ff, tgt_ff, h_ff, cur_ff, blk_ff, orig_ff, best_ff, bsz_ff;
   logic [bfha_pkg::ADDR_W-1:0] addr_ff;
   logic found_ff;
   logic [BW-1:0] fbc_ff;
   logic [bfha_pkg::ADDR_W-1:0] res_ff;
   logic ok_ff, moved_ff;
   logic [BW-1:0] copy_ff;

   logic [SW-1:0] rd_size, nx, skip_h, merged, want_in, tgt_in, min_sz;
   logic rd_free, fit, split, is_resize;
   logic we, re;
   logic [SW-1:0] wa, ra;
   logic [AW:0] wd;

   assign rd_size = SW'(rd_ff[AW-1:0]);
   assign rd_free = rd_ff[AW];
   assign nx = h_ff + ONE + cur_ff;
   assign skip_h = h_ff + ONE + rd_size;
   assign merged = cur_ff + ONE + rd_size;
   assign want_in = SW'(({1'b0, req_data.size_bytes} + (BW + 1)'(3)) >> 2);
   assign tgt_in = SW'(req_data.block_addr) - ONE;
   assign fit = (want_ff <= cur_ff) && (!found_ff || (cur_ff < bsz_ff));
   assign split = bsz_ff > (want_ff + ONE);
   assign is_resize = cmd_ff == bfha_pkg::CMD_RESIZE;
   assign min_sz = (orig_ff < want_ff) ? orig_ff : want_ff;

   always_comb begin
      status.cmd = cmd_ff;
      status.bad_addr = (addr_ff == '0) || (tgt_ff >= HW_S);
      status.h_end = h_ff >= HW_S;
      status.h_past_tgt = h_ff > tgt_ff;
      status.h_eq_tgt = h_ff == tgt_ff;
      status.rd_free = rd_free;
      status.nx_end = nx >= HW_S;
      status.cur_ge_want = cur_ff >= want_ff;
      status.trim_ok = cur_ff >= (want_ff + TRIM_S);
      status.found = found_ff;
      status.split = split;
   end

   always_comb begin
      we = 1'b0;
      re = 1'b0;
      wa = '0;
      ra = h_ff;
      wd = '0;
      case (op)
         bfha_pkg::OP_INIT: begin
            we = 1'b1;
            wd = {1'b1, TOP_SIZE};
         end
         bfha_pkg::OP_RD_H: begin
            re = 1'b1;
         end
         bfha_pkg::OP_RD_NX: begin
            re = 1'b1;
            ra = nx;
         end
         bfha_pkg::OP_MERGE_A: begin
            we = 1'b1;
            wa = h_ff;
            wd = {1'b1, merged[AW-1:0]};
         end
         bfha_pkg::OP_MERGE_R: begin
            we = 1'b1;
            wa = h_ff;
            wd = {1'b0, merged[AW-1:0]};
         end
         bfha_pkg::OP_TAKE: begin
            we = 1'b1;
            wa = best_ff;
            wd = {1'b0, split ? want_ff[AW-1:0] : bsz_ff[AW-1:0]};
         end
         bfha_pkg::OP_SPLIT: begin
            we = 1'b1;
            wa = best_ff + ONE + want_ff;
            wd = {1'b1, AW'(bsz_ff - want_ff - ONE)};
         end
         bfha_pkg::OP_FREE: begin
            we = 1'b1;
            wa = tgt_ff;
            wd = {1'b1, blk_ff[AW-1:0]};
         end
         bfha_pkg::OP_TRIM: begin
            we = 1'b1;
            wa = tgt_ff;
            wd = {1'b0, want_ff[AW-1:0]};
         end
         bfha_pkg::OP_TRIM2: begin
            we = 1'b1;
            wa = tgt_ff + ONE + want_ff;
            wd = {1'b1, AW'(cur_ff - want_ff - ONE)};
         end
         default: begin
            we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa[AW-1:0]] <= wd;
      end
      if (re) begin
         rd_ff <= mem[ra[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      case (op)
         bfha_pkg::OP_INIT: begin
            fbc_ff <= FBC_RESET;
         end
         bfha_pkg::OP_LOAD: begin
            cmd_ff <= req_data.cmd;
            want_ff <= want_in;
            addr_ff <= req_data.block_addr;
            tgt_ff <= tgt_in;
            h_ff <= '0;
            found_ff <= 1'b0;
         end
         bfha_pkg::OP_SKIP: begin
            h_ff <= skip_h;
         end
         bfha_pkg::OP_LATCH: begin
            cur_ff <= rd_size;
         end
         bfha_pkg::OP_VALID: begin
            cur_ff <= rd_size;
            blk_ff <= rd_size;
            orig_ff <= rd_size;
         end
         bfha_pkg::OP_MERGE_A: begin
            cur_ff <= merged;
            fbc_ff <= fbc_ff + BW'(4);
         end
         bfha_pkg::OP_MERGE_R: begin
            cur_ff <= merged;
            fbc_ff <= fbc_ff - to_bytes(rd_size);
         end
         bfha_pkg::OP_FIT: begin
            if (fit) begin
               best_ff <= h_ff;
               bsz_ff <= cur_ff;
               found_ff <= 1'b1;
            end
            h_ff <= nx;
         end
         bfha_pkg::OP_ALLOC_START: begin
            blk_ff <= cur_ff;
            h_ff <= '0;
            found_ff <= 1'b0;
         end
         bfha_pkg::OP_TAKE: begin
            fbc_ff <= fbc_ff - (split ? to_bytes(want_ff + ONE) : to_bytes(bsz_ff));
         end
         bfha_pkg::OP_FREE: begin
            fbc_ff <= fbc_ff + to_bytes(blk_ff);
         end
         bfha_pkg::OP_TRIM2: begin
            fbc_ff <= fbc_ff + to_bytes(cur_ff - want_ff - ONE);
         end
         bfha_pkg::OP_RES_FAIL: begin
            res_ff <= '0;
            ok_ff <= 1'b0;
            moved_ff <= 1'b0;
            copy_ff <= '0;
         end
         bfha_pkg::OP_RES_FREE: begin
            res_ff <= '0;
            ok_ff <= 1'b1;
            moved_ff <= 1'b0;
            copy_ff <= '0;
         end
         bfha_pkg::OP_RES_ADDR: begin
            res_ff <= addr_ff;
            ok_ff <= 1'b1;
            moved_ff <= 1'b0;
            copy_ff <= '0;
         end
         bfha_pkg::OP_RES_BEST: begin
            res_ff <= bfha_pkg::ADDR_W'(best_ff + ONE);
            ok_ff <= 1'b1;
            moved_ff <= is_resize;
            copy_ff <= is_resize ? to_bytes(min_sz) : '0;
         end
         default: begin
            h_ff <= h_ff;
         end
      endcase
   end

   always_comb begin
      rsp_data.result_addr = res_ff;
      rsp_data.ok = ok_ff;
      rsp_data.moved = moved_ff;
      rsp_data.copy_bytes = copy_ff;
      rsp_data.bytes_free = fbc_ff;
   end

endmodule
`default_nettype wire

>>> hdl/bfha_ctrl.sv
`default_nettype none
module bfha_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   input  bfha_pkg::dp_status_type status,
   output bfha_pkg::op_type        op,
   output logic                    busy,
   output logic                    rsp_valid
);

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_DISPATCH,
      S_A_RD, S_A_HDR, S_A_MRD, S_A_MCHK, S_A_FIT, S_A_DONE, S_A_SPLIT,
      S_A_FREE_OLD, S_A_RESULT,
      S_V_RD, S_V_HDR, S_F_DO, S_F_RES,
      S_R_CHK, S_R_MCHK, S_R_ALLOC, S_R_TRIM, S_R_TRIM2, S_R_RES,
      S_FAIL
   } state_type;

   state_type state_ff, state_in;
   logic busy_ff, rsp_valid_ff, done;

   always_comb begin
      state_in = state_ff;
      op = bfha_pkg::OP_NONE;
      done = 1'b0;
      case (state_ff)
         S_INIT: begin
            op = bfha_pkg::OP_INIT;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               op = bfha_pkg::OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (status.cmd)
               bfha_pkg::CMD_ALLOC: state_in = S_A_RD;
               bfha_pkg::CMD_FREE,
               bfha_pkg::CMD_RESIZE: state_in = status.bad_addr ? S_FAIL : S_V_RD;
               default: state_in = S_FAIL;
            endcase
         end
         S_A_RD: begin
            if (status.h_end) begin
               state_in = S_A_DONE;
            end else begin
               op = bfha_pkg::OP_RD_H;
               state_in = S_A_HDR;
            end
         end
         S_A_HDR: begin
            if (status.rd_free) begin
               op = bfha_pkg::OP_LATCH;
               state_in = S_A_MRD;
            end else begin
               op = bfha_pkg::OP_SKIP;
               state_in = S_A_RD;
            end
         end
         S_A_MRD: begin
            if (status.nx_end) begin
               state_in = S_A_FIT;
            end else begin
               op = bfha_pkg::OP_RD_NX;
               state_in = S_A_MCHK;
            end
         end
         S_A_MCHK: begin
            if (status.rd_free) begin
               op = bfha_pkg::OP_MERGE_A;
               state_in = S_A_MRD;
            end else begin
               state_in = S_A_FIT;
            end
         end
         S_A_FIT: begin
            op = bfha_pkg::OP_FIT;
            state_in = S_A_RD;
         end
         S_A_DONE: begin
            if (!status.found) begin
               state_in = S_FAIL;
            end else begin
               op = bfha_pkg::OP_TAKE;
               if (status.split) begin
                  state_in = S_A_SPLIT;
               end else if (status.cmd == bfha_pkg::CMD_RESIZE) begin
                  state_in = S_A_FREE_OLD;
               end else begin
                  state_in = S_A_RESULT;
               end
            end
         end
         S_A_SPLIT: begin
            op = bfha_pkg::OP_SPLIT;
            state_in = (status.cmd == bfha_pkg::CMD_RESIZE) ? S_A_FREE_OLD : S_A_RESULT;
         end
         S_A_FREE_OLD: begin
            op = bfha_pkg::OP_FREE;
            state_in = S_A_RESULT;
         end
         S_A_RESULT: begin
            op = bfha_pkg::OP_RES_BEST;
            done = 1'b1;
            state_in = S_IDLE;
         end
         S_V_RD: begin
            if (status.h_past_tgt) begin
               state_in = S_FAIL;
            end else begin
               op = bfha_pkg::OP_RD_H;
               state_in = S_V_HDR;
            end
         end
         S_V_HDR: begin
            if (!status.h_eq_tgt) begin
               op = bfha_pkg::OP_SKIP;
               state_in = S_V_RD;
            end else if (status.rd_free) begin
               state_in = S_FAIL;
            end else begin
               op = bfha_pkg::OP_VALID;
               state_in = (status.cmd == bfha_pkg::CMD_FREE) ? S_F_DO : S_R_CHK;
            end
         end
         S_F_DO: begin
            op = bfha_pkg::OP_FREE;
            state_in = S_F_RES;
         end
         S_F_RES: begin
            op = bfha_pkg::OP_RES_FREE;
            done = 1'b1;
            state_in = S_IDLE;
         end
         S_R_CHK: begin
            if (status.cur_ge_want) begin
               state_in = S_R_TRIM;
            end else if (status.nx_end) begin
               state_in = S_R_ALLOC;
            end else begin
               op = bfha_pkg::OP_RD_NX;
               state_in = S_R_MCHK;
            end
         end
         S_R_MCHK: begin
            if (status.rd_free) begin
               op = bfha_pkg::OP_MERGE_R;
               state_in = S_R_CHK;
            end else begin
               state_in = S_R_ALLOC;
            end
         end
         S_R_ALLOC: begin
            op = bfha_pkg::OP_ALLOC_START;
            state_in = S_A_RD;
         end
         S_R_TRIM: begin
            if (status.trim_ok) begin
               op = bfha_pkg::OP_TRIM;
               state_in = S_R_TRIM2;
            end else begin
               state_in = S_R_RES;
            end
         end
         S_R_TRIM2: begin
            op = bfha_pkg::OP_TRIM2;
            state_in = S_R_RES;
         end
         S_R_RES: begin
            op = bfha_pkg::OP_RES_ADDR;
            done = 1'b1;
            state_in = S_IDLE;
         end
         S_FAIL: begin
            op = bfha_pkg::OP_RES_FAIL;
            done = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         busy_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff <= state_in != S_IDLE;
         rsp_valid_ff <= done;
      end
   end

   assign busy = busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

>>> hdl/best_fit_heap_allocator_top.sv
// Best-fit heap allocator over a heap of HEAP_WORDS words with in-band headers.
// A request is taken at a rising edge where start is high and busy is low; it
// carries a command (allocate, free or resize), a byte size and a block address.
// Each request produces exactly one result, shown on rsp_data for the single
// cycle in which rsp_valid is high. The receiver cannot stall, so it must take
// the result in that cycle; busy drops in the same cycle and a new request may
// be presented right away.
// The header memory has a registered read port and the walk reads one header at
// a time; a free block costs more than a block in use, every merge of a free
// neighbor adds to that, and dispatch, splitting and reporting come on top.
// Allocate walks the whole heap; free and resize walk to the named block first,
// and a resize that moves the block adds a full allocate walk. Only one request
// is in flight at a time.
// After reset the block writes the single whole-heap free header at word 0 with
// busy high; no clearing of the memory is needed since only headers reachable
// from word 0 are ever read.
`default_nettype none
module best_fit_heap_allocator_top #(
   parameter int HEAP_WORDS = bfha_pkg::HEAP_WORDS_DEFAULT
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  bfha_pkg::req_type  req_data,
   output logic               rsp_valid,
   output bfha_pkg::rsp_type  rsp_data
);

   // Controller and datapath talk only through the operation code and status.
   bfha_pkg::op_type        op;
   bfha_pkg::dp_status_type status;

   bfha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .op        (op),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   bfha_dp #(
      .HEAP_WORDS (HEAP_WORDS)
   ) u_dp (
      .clock    (clock),
      .op       (op),
      .req_data (req_data),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

>>> hdl/bfha_chk.sv
`default_nettype none
`include "best_fit_heap_allocator_top_macros.svh"
module bfha_chk (
   input wire               clock,
   input wire               reset,
   input wire               start,
   input wire               busy,
   input wire               rsp_valid,
   input bfha_pkg::rsp_type rsp_data
);

   `BFHA_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, busy && !rsp_valid)
   `BFHA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `BFHA_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid)
   `BFHA_ASSERT_NOW(a_fail_clean, clock, reset, rsp_valid && !rsp_data.ok, (rsp_data.result_addr == '0) && !rsp_data.moved)
   `BFHA_ASSERT_NOW(a_moved_ok, clock, reset, rsp_valid && rsp_data.moved, rsp_data.ok && (rsp_data.result_addr != '0))

endmodule

bind best_fit_heap_allocator_top bfha_chk u_bfha_chk (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
`default_nettype wire

>>> test/tb.sv
`default_nettype none
module tb;

   // The heap size the block is built with; the predictor mirrors it.
   localparam int unsigned HEAP = bfha_pkg::HEAP_WORDS_DEFAULT;
   // Cycles with no request taken and no result seen before the run is declared hung.
   // One allocate walks at most a few hundred headers here; a moving resize walks twice.
   localparam int unsigned HANG_LIMIT = 40000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   bfha_pkg::req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   bfha_pkg::rsp_type rsp_data;

   best_fit_heap_allocator_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // Shadow copy of the heap: payload words, free flag and header marker per word.
   int unsigned blk_words [HEAP];
   bit          blk_is_free [HEAP];
   bit          blk_is_hdr [HEAP];
   int unsigned free_bytes;

   // Payload addresses of blocks the shadow heap holds in use, and ones released since.
   int unsigned live_addrs [$];
   int unsigned dead_addrs [$];

   bfha_pkg::req_type pending_reqs [$];
   bfha_pkg::rsp_type expected_rsps [$];
   int unsigned issued_cnt = 0;
   int unsigned taken_cnt = 0;
   int unsigned driven_cnt = 0;
   int unsigned error_cnt = 0;
   int unsigned idle_pct = 0;
   int unsigned quiet_cycles = 0;

   function automatic void heap_reset();
      for (int unsigned i = 0; i < HEAP; i++) begin
         blk_words[i] = 0;
         blk_is_free[i] = 1'b0;
         blk_is_hdr[i] = 1'b0;
      end
      blk_words[0] = HEAP - 1;
      blk_is_free[0] = 1'b1;
      blk_is_hdr[0] = 1'b1;
      free_bytes = (HEAP - 1) * 4;
   endfunction

   // Best-fit walk from word 0, coalescing free runs on the way.
   // Returns the header index of the granted block, or HEAP when nothing fits.
   function automatic int unsigned best_fit_grant(int unsigned want);
      int unsigned h, best, best_sz, nx, sz;
      h = 0;
      best = HEAP;
      best_sz = 0;
      while (h < HEAP) begin
         if (blk_is_free[h]) begin
            while (1) begin
               nx = h + 1 + blk_words[h];
               if (nx >= HEAP || !blk_is_free[nx]) break;
               blk_words[h] = blk_words[h] + 1 + blk_words[nx];
               blk_is_hdr[nx] = 1'b0;
               free_bytes += 4;
            end
            sz = blk_words[h];
            if (want <= sz && (best == HEAP || sz < best_sz)) begin
               best = h;
               best_sz = sz;
            end
         end
         h = h + 1 + blk_words[h];
      end
      if (best == HEAP) return HEAP;
      if (best_sz > want + 1) begin
         blk_words[best] = want;
         blk_is_free[best] = 1'b0;
         nx = best + 1 + want;
         blk_words[nx] = best_sz - want - 1;
         blk_is_free[nx] = 1'b1;
         blk_is_hdr[nx] = 1'b1;
         free_bytes -= (want + 1) * 4;
      end else begin
         blk_is_free[best] = 1'b0;
         free_bytes -= best_sz * 4;
      end
      return best;
   endfunction

   // Header of the in-use block named by a payload address, or HEAP if there is none.
   function automatic int unsigned used_header(int unsigned addr);
      if (addr == 0 || addr > HEAP) return HEAP;
      if (!blk_is_hdr[addr-1] || blk_is_free[addr-1]) return HEAP;
      return addr - 1;
   endfunction

   function automatic void forget_live(int unsigned addr);
      foreach (live_addrs[i]) begin
         if (live_addrs[i] == addr) begin
            live_addrs.delete(i);
            break;
         end
      end
   endfunction

   // Applies one request to the shadow heap and returns the result it must produce.
   function automatic bfha_pkg::rsp_type heap_apply(bfha_pkg::req_type rq);
      bfha_pkg::rsp_type r;
      int unsigned want, h, nh, nx, orig, bsz;
      bit          grown;
      r = '0;
      want = (32'(rq.size_bytes) + 3) >> 2;
      case (rq.cmd)
         bfha_pkg::CMD_ALLOC: begin
            h = best_fit_grant(want);
            if (h != HEAP) begin
               r.result_addr = 16'(h + 1);
               r.ok = 1'b1;
               live_addrs.push_back(h + 1);
            end
         end
         bfha_pkg::CMD_FREE: begin
            h = used_header(32'(rq.block_addr));
            if (h != HEAP) begin
               free_bytes += blk_words[h] * 4;
               blk_is_free[h] = 1'b1;
               r.ok = 1'b1;
               forget_live(h + 1);
               dead_addrs.push_back(h + 1);
            end
         end
         bfha_pkg::CMD_RESIZE: begin
            h = used_header(32'(rq.block_addr));
            if (h != HEAP) begin
               orig = blk_words[h];
               grown = 1'b1;
               while (blk_words[h] < want) begin
                  nx = h + 1 + blk_words[h];
                  if (nx >= HEAP || !blk_is_free[nx]) begin
                     grown = 1'b0;
                     break;
                  end
                  free_bytes -= blk_words[nx] * 4;
                  blk_words[h] = blk_words[h] + 1 + blk_words[nx];
                  blk_is_hdr[nx] = 1'b0;
               end
               if (grown) begin
                  bsz = blk_words[h];
                  // Trim only when the surplus pays for a header and a few words.
                  if (bsz >= want + bfha_pkg::TRIM_MIN_WORDS) begin
                     blk_words[h] = want;
                     nx = h + 1 + want;
                     blk_words[nx] = bsz - want - 1;
                     blk_is_free[nx] = 1'b1;
                     blk_is_hdr[nx] = 1'b1;
                     free_bytes += (bsz - want - 1) * 4;
                  end
                  r.result_addr = rq.block_addr;
                  r.ok = 1'b1;
               end else begin
                  nh = best_fit_grant(want);
                  if (nh != HEAP) begin
                     free_bytes += blk_words[h] * 4;
                     blk_is_free[h] = 1'b1;
                     r.result_addr = 16'(nh + 1);
                     r.ok = 1'b1;
                     r.moved = 1'b1;
                     r.copy_bytes = 18'(((orig < want) ? orig : want) * 4);
                     forget_live(h + 1);
                     dead_addrs.push_back(h + 1);
                     live_addrs.push_back(nh + 1);
                  end
               end
            end
         end
         default: ;
      endcase
      r.bytes_free = 18'(free_bytes);
      return r;
   endfunction

   // A request is taken at the edge where start is high and busy is low; predict it then.
   always @(posedge clock) begin
      if (reset) begin
         heap_reset();
      end else if (start && !busy) begin
         expected_rsps.push_back(heap_apply(req_data));
         taken_cnt++;
      end
   end

   // Results must match the oldest outstanding prediction, field by field.
   always @(posedge clock) begin
      bfha_pkg::rsp_type ex;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $error("result arrived with no request outstanding");
            error_cnt++;
         end else begin
            ex = expected_rsps.pop_front();
            if (rsp_data.result_addr !== ex.result_addr) begin
               $error("result_addr expected %0d actual %0d", ex.result_addr, rsp_data.result_addr);
               error_cnt++;
            end
            if (rsp_data.ok !== ex.ok) begin
               $error("ok expected %0d actual %0d", ex.ok, rsp_data.ok);
               error_cnt++;
            end
            if (rsp_data.moved !== ex.moved) begin
               $error("moved expected %0d actual %0d", ex.moved, rsp_data.moved);
               error_cnt++;
            end
            if (rsp_data.copy_bytes !== ex.copy_bytes) begin
               $error("copy_bytes expected %0d actual %0d", ex.copy_bytes, rsp_data.copy_bytes);
               error_cnt++;
            end
            if (rsp_data.bytes_free !== ex.bytes_free) begin
               $error("bytes_free expected %0d actual %0d", ex.bytes_free, rsp_data.bytes_free);
               error_cnt++;
            end
         end
      end
   end

   // Watchdog: any taken request or seen result counts as progress.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= HANG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Driver: once every presented request has been taken, present the next pending
   // request unless this cycle is rolled as a sender gap. Start is held across
   // back-to-back requests rather than dropped and raised in one step.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (taken_cnt == driven_cnt) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
            req_data <= pending_reqs.pop_front();
            start <= 1'b1;
            driven_cnt++;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Queues one request and waits until the block has taken it, so that the next
   // request can be chosen from the updated shadow heap.
   task automatic send(bfha_pkg::cmd_type c, int unsigned sz, int unsigned addr);
      bfha_pkg::req_type rq;
      rq.cmd = c;
      rq.size_bytes = 18'(sz);
      rq.block_addr = 16'(addr);
      pending_reqs.push_back(rq);
      issued_cnt++;
      wait (taken_cnt == issued_cnt);
   endtask

   task automatic drain();
      wait (taken_cnt == issued_cnt && expected_rsps.size() == 0);
   endtask

   function automatic int unsigned pick_live();
      return live_addrs[$urandom_range(live_addrs.size() - 1)];
   endfunction

   initial begin
      int unsigned a, b, c, r, n;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. The whole heap fits exactly one block of the largest size.
      send(bfha_pkg::CMD_ALLOC, 262140, 0);
      send(bfha_pkg::CMD_ALLOC, 0, 0);               // nothing left, even for a header-only block
      send(bfha_pkg::CMD_RESIZE, 0, live_addrs[0]);  // shrink to zero words, big surplus trimmed
      send(bfha_pkg::CMD_FREE, 0, live_addrs[0]);
      send(bfha_pkg::CMD_ALLOC, 262137, 0);          // rounds up to the whole heap again
      send(bfha_pkg::CMD_FREE, 0, live_addrs[0]);
      send(bfha_pkg::CMD_ALLOC, 8, 0);
      a = live_addrs[$];
      send(bfha_pkg::CMD_ALLOC, 8, 0);
      b = live_addrs[$];
      send(bfha_pkg::CMD_ALLOC, 4, 0);
      c = live_addrs[$];
      send(bfha_pkg::CMD_RESIZE, 400, a);            // blocked by a used neighbor, so it moves
      send(bfha_pkg::CMD_FREE, 0, c);
      send(bfha_pkg::CMD_RESIZE, 20, b);             // merges the freed neighbor but still falls short, so it moves
      send(bfha_pkg::CMD_RESIZE, 262140, b);         // old address of b, now a free block, so it fails
      send(bfha_pkg::CMD_RESIZE, 10, b);             // old address again, so it fails as well
      send(bfha_pkg::cmd_type'(2'd3), 262143, 65535);  // unknown command
      send(bfha_pkg::CMD_FREE, 0, 0);
      send(bfha_pkg::CMD_RESIZE, 4, 0);
      send(bfha_pkg::CMD_FREE, 0, 65535);
      send(bfha_pkg::CMD_FREE, 0, c);                // already free
      send(bfha_pkg::CMD_RESIZE, 8, c);
      send(bfha_pkg::CMD_ALLOC, 1, 0);
      send(bfha_pkg::CMD_ALLOC, 0, 0);
      drain();

      // Random part in four idling phases; the sender waits for every result
      // at each phase boundary.
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = (ph == 1) ? 64 : (ph == 3) ? 23 : 0;
         for (n = 0; n < 138; n++) begin
            r = $urandom_range(99);
            if (live_addrs.size() > 40 && r < 40) r = 50;
            if (live_addrs.size() == 0 && r < 85) r = 0;
            if (r < 40) begin
               if ($urandom_range(9) == 0) send(bfha_pkg::CMD_ALLOC, $urandom_range(262140), 0);
               else send(bfha_pkg::CMD_ALLOC, $urandom_range(256), 0);
            end else if (r < 65) begin
               send(bfha_pkg::CMD_FREE, $urandom_range(262143), pick_live());
            end else if (r < 85) begin
               if ($urandom_range(9) == 0)
                  send(bfha_pkg::CMD_RESIZE, $urandom_range(262143), pick_live());
               else
                  send(bfha_pkg::CMD_RESIZE, $urandom_range(320), pick_live());
            end else begin
               case ($urandom_range(3))
                  0: send(bfha_pkg::cmd_type'(2'd3), $urandom_range(262143),
                          $urandom_range(65535));
                  1: send(bfha_pkg::CMD_FREE, $urandom_range(262143), $urandom_range(65535));
                  2: send(bfha_pkg::CMD_RESIZE, $urandom_range(262143), $urandom_range(65535));
                  default: begin
                     if (dead_addrs.size() > 0)
                        send(bfha_pkg::CMD_FREE, 0,
                             dead_addrs[$urandom_range(dead_addrs.size() - 1)]);
                     else
                        send(bfha_pkg::CMD_FREE, 0, 0);
                  end
               endcase
            end
         end
         drain();
      end

      repeat (200) @(posedge clock);
      if (error_cnt == 0 && expected_rsps.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
`default_nettype wire
